@@ hw/rtl/pls_pkg.sv @@
// pls_pkg: shared types and codes for the positional list store
// request and result payload structs, request codes, controller states and commands
// no dependencies
package pls_pkg;

    // request codes carried in the func field
    localparam logic [2:0] FUNC_APPEND      = 3'd0;
    localparam logic [2:0] FUNC_INSERT      = 3'd1;
    localparam logic [2:0] FUNC_REMOVE_LAST = 3'd2;
    localparam logic [2:0] FUNC_REMOVE_AT   = 3'd3;
    localparam logic [2:0] FUNC_READ        = 3'd4;

    localparam int unsigned POS_W   = 4;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic [2:0]        func;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  element_out;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INSERT,
        SH_REMOVE
    } shift_t;

    typedef enum logic [1:0] {
        TGT_END,
        TGT_LAST,
        TGT_POS
    } target_t;

    typedef struct packed {
        logic    load;
        logic    capture;
        logic    ok;
        logic    read_en;
        shift_t  shift;
        target_t target;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       empty;
        logic       pos_lt_held;
    } dp_status_t;

endpackage

@@ hw/rtl/pls_datapath.sv @@
// pls_datapath: request register, chain of shifting slot cells, count and result register
// depends on pls_pkg
// driven by pls_ctrl through ctrl_cmd_t, reports back through dp_status_t
module pls_datapath #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pls_pkg::in_item_t    in_item,
    input  pls_pkg::ctrl_cmd_t   cmd,
    output pls_pkg::dp_status_t  status,
    output pls_pkg::out_item_t   out_item
);

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMPW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
    localparam int unsigned EW   = ELEMENT_WIDTH;
    localparam int unsigned WW   = pls_pkg::WORD_W;

    pls_pkg::in_item_t  req_reg;
    pls_pkg::out_item_t res_reg;
    logic [CW-1:0]      held_reg;
    logic [CW-1:0]      held_next;
    logic [EW-1:0]      slot_reg  [CAPACITY];
    logic [EW-1:0]      slot_next [CAPACITY];

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    held_ext;
    logic [CW-1:0]      pos_clamp;
    logic [CW-1:0]      target;
    logic [EW-1:0]      word_in;
    logic [EW+WW-1:0]   word_wide;
    logic [EW+WW-1:0]   read_wide;
    logic [EW-1:0]      read_word;
    logic [CW+pls_pkg::COUNT_W-1:0] count_wide;

    assign pos_ext  = CMPW'(req_reg.position);
    assign held_ext = CMPW'(held_reg);

    assign status.func        = req_reg.func;
    assign status.full        = (held_reg == CW'(CAPACITY));
    assign status.empty       = (held_reg == '0);
    assign status.pos_lt_held = (pos_ext < held_ext);

    // insert past the end lands at the end
    assign pos_clamp = (pos_ext > held_ext) ? held_reg : pos_ext[CW-1:0];

    always_comb
    begin
        case (cmd.target)
            pls_pkg::TGT_END:  target = held_reg;
            pls_pkg::TGT_LAST: target = held_reg - CW'(1);
            pls_pkg::TGT_POS:  target = pos_clamp;
            default:           target = pos_clamp;
        endcase
    end

    // element masked to the stored width
    assign word_wide = {{EW{1'b0}}, req_reg.element};
    assign word_in   = word_wide[EW-1:0];

    // each cell takes its lower or upper neighbor, the new word, or holds
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [EW-1:0] below;
            logic [EW-1:0] above;
            if (i == 0)
            begin : g_bottom
                assign below = '0;
            end
            else
            begin : g_mid_lo
                assign below = slot_reg[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_top
                assign above = slot_reg[i];
            end
            else
            begin : g_mid_hi
                assign above = slot_reg[i+1];
            end

            always_comb
            begin
                slot_next[i] = slot_reg[i];
                case (cmd.shift)
                    pls_pkg::SH_INSERT:
                    begin
                        if (CW'(i) == target)
                            slot_next[i] = word_in;
                        else if (CW'(i) > target)
                            slot_next[i] = below;
                    end
                    pls_pkg::SH_REMOVE:
                    begin
                        if (CW'(i) >= target)
                            slot_next[i] = above;
                    end
                    default: slot_next[i] = slot_reg[i];
                endcase
            end

            always_ff @(posedge clk)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        case (cmd.shift)
            pls_pkg::SH_INSERT: held_next = held_reg + CW'(1);
            pls_pkg::SH_REMOVE: held_next = held_reg - CW'(1);
            default:            held_next = held_reg;
        endcase
    end

    assign read_word  = slot_reg[pos_ext[IW-1:0]];
    assign read_wide  = {{WW{1'b0}}, read_word};
    assign count_wide = {{pls_pkg::COUNT_W{1'b0}}, held_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else
            held_reg <= held_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_item;
        if (cmd.capture)
        begin
            res_reg.status      <= !cmd.ok;
            res_reg.element_out <= (cmd.ok && cmd.read_en) ? read_wide[WW-1:0] : '0;
            res_reg.count       <= count_wide[pls_pkg::COUNT_W-1:0];
        end
    end

    assign out_item = res_reg;

endmodule

@@ hw/rtl/pls_ctrl.sv @@
// pls_ctrl: request sequencer for the positional list store
// depends on pls_pkg
// decodes the held request against datapath status and issues one command per step
module pls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pls_pkg::dp_status_t  status,
    output pls_pkg::ctrl_cmd_t   cmd
);

    pls_pkg::state_t state_reg;
    pls_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pls_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pls_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pls_pkg::ST_EXEC;
            end
            pls_pkg::ST_EXEC: state_next = pls_pkg::ST_RESP;
            pls_pkg::ST_RESP:
            begin
                if (out_ready)
                    state_next = pls_pkg::ST_IDLE;
            end
            default: state_next = pls_pkg::ST_IDLE;
        endcase
    end

    // decode of the held request
    logic              dec_ok;
    logic              dec_read;
    pls_pkg::shift_t   dec_shift;
    pls_pkg::target_t  dec_target;

    always_comb
    begin
        dec_ok     = 1'b0;
        dec_read   = 1'b0;
        dec_shift  = pls_pkg::SH_NONE;
        dec_target = pls_pkg::TGT_POS;
        case (status.func)
            pls_pkg::FUNC_APPEND:
            begin
                dec_ok     = !status.full;
                dec_shift  = pls_pkg::SH_INSERT;
                dec_target = pls_pkg::TGT_END;
            end
            pls_pkg::FUNC_INSERT:
            begin
                dec_ok     = !status.full;
                dec_shift  = pls_pkg::SH_INSERT;
            end
            pls_pkg::FUNC_REMOVE_LAST:
            begin
                dec_ok     = !status.empty;
                dec_shift  = pls_pkg::SH_REMOVE;
                dec_target = pls_pkg::TGT_LAST;
            end
            pls_pkg::FUNC_REMOVE_AT:
            begin
                dec_ok     = status.pos_lt_held;
                dec_shift  = pls_pkg::SH_REMOVE;
            end
            pls_pkg::FUNC_READ:
            begin
                dec_ok     = status.pos_lt_held;
                dec_read   = 1'b1;
            end
            default: dec_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.capture = 1'b0;
        cmd.ok      = dec_ok;
        cmd.read_en = dec_read;
        cmd.shift   = pls_pkg::SH_NONE;
        cmd.target  = dec_target;
        case (state_reg)
            pls_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pls_pkg::ST_EXEC:
            begin
                cmd.capture = 1'b1;
                // a failed request leaves the list untouched
                cmd.shift   = dec_ok ? dec_shift : pls_pkg::SH_NONE;
            end
            pls_pkg::ST_RESP: out_valid = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/positional_list_store_top.sv @@
// positional_list_store_top: bounded ordered list with insert, remove and read by position
// depends on pls_pkg, pls_ctrl, pls_datapath
//
//   channel   handshake               payload
//   in        in_valid / in_ready     in_item  (func, position, element)
//   out       out_valid / out_ready   out_item (status, element_out, count)
//
// one request at a time: transfer in, execute state, result held until transfer out;
// the controller steps through its idle, execute and response states in that order
// the whole shift of the slot chain happens in the execute cycle
// reset clears the count and the controller; slot contents are not cleared
// a stalled result holds the block; no new request is taken until it is transferred
module positional_list_store_top #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pls_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pls_pkg::out_item_t  out_item
);

    pls_pkg::ctrl_cmd_t  cmd;
    pls_pkg::dp_status_t status;

    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pls_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

@@ verif/tb_positional_list_store_top.sv @@
// tb_positional_list_store_top: self-checking bench for the positional list store
// holds a shadow copy of the list, predicts every result and compares each output transfer
// depends on pls_pkg and positional_list_store_top
module tb_positional_list_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP       = 16;
    localparam int unsigned RAND_REQS = 800;
    localparam int unsigned QUIET_AT  = 700;
    localparam int unsigned HOLD_AT   = 300;
    localparam int unsigned DRAIN_AT  = 500;
    localparam int unsigned HOLD_LEN  = 100;
    localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;

    class list_shadow;
        logic [pls_pkg::WORD_W-1:0] slots [CAP];
        int unsigned                held;
        pls_pkg::out_item_t         expected_results [$];
        int unsigned                failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function bit place_word(int unsigned pos, logic [pls_pkg::WORD_W-1:0] word);
            int unsigned i;
            if (held >= CAP)
                return 1'b0;
            if (pos > held)
                pos = held;
            for (i = held; i > pos; i--)
                slots[i] = slots[i-1];
            slots[pos] = word;
            held++;
            return 1'b1;
        endfunction

        function bit drop_word(int unsigned pos);
            int unsigned i;
            if (held == 0 || pos >= held)
                return 1'b0;
            for (i = pos; i + 1 < held; i++)
                slots[i] = slots[i+1];
            held--;
            return 1'b1;
        endfunction

        function pls_pkg::out_item_t predict_request(pls_pkg::in_item_t req);
            pls_pkg::out_item_t         res;
            bit                         ok;
            logic [pls_pkg::WORD_W-1:0] got;
            ok = 1'b0;
            got = '0;
            case (req.func)
                pls_pkg::FUNC_APPEND:      ok = place_word(held, req.element);
                pls_pkg::FUNC_INSERT:      ok = place_word(req.position, req.element);
                pls_pkg::FUNC_REMOVE_LAST: ok = (held != 0) && drop_word(held - 1);
                pls_pkg::FUNC_REMOVE_AT:   ok = drop_word(req.position);
                pls_pkg::FUNC_READ:
                begin
                    if (req.position < held)
                    begin
                        got = slots[req.position];
                        ok = 1'b1;
                    end
                end
                default:                   ok = 1'b0;
            endcase
            res.status = !ok;
            res.element_out = ok ? got : '0;
            res.count = pls_pkg::COUNT_W'(held);
            return res;
        endfunction

        function void note_request(pls_pkg::in_item_t req);
            expected_results.push_back(predict_request(req));
        endfunction

        function void check_result(pls_pkg::out_item_t got);
            pls_pkg::out_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %p", got);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.element_out !== want.element_out)
            begin
                $error("element_out: expected %h, actual %h", want.element_out, got.element_out);
                failures++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    pls_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_ready;
    pls_pkg::out_item_t out_item;

    list_shadow shadow = new();
    bit         quiet = 1'b0;
    bit         long_hold_req = 1'b0;

    positional_list_store_top #(
        .CAPACITY      (CAP),
        .ELEMENT_WIDTH (pls_pkg::WORD_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            shadow.note_request(in_item);
        if (rst_n && out_valid && out_ready)
            shadow.check_result(out_item);
    end

    // receiver: random stalls, one long hold on request, none in the quiet tail
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_req(logic [2:0] func, logic [pls_pkg::POS_W-1:0] pos,
                            logic [pls_pkg::WORD_W-1:0] word);
        pls_pkg::in_item_t req;
        req.func = func;
        req.position = pos;
        req.element = word;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(bit filling);
        int unsigned                roll;
        logic [2:0]                 func;
        logic [pls_pkg::WORD_W-1:0] word;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else if (roll < 25)
            func = pls_pkg::FUNC_READ;
        else if (filling)
            func = (roll < 50) ? pls_pkg::FUNC_APPEND : (roll < 85) ? pls_pkg::FUNC_INSERT :
                   (roll < 92) ? pls_pkg::FUNC_REMOVE_LAST : pls_pkg::FUNC_REMOVE_AT;
        else
            func = (roll < 33) ? pls_pkg::FUNC_APPEND : (roll < 43) ? pls_pkg::FUNC_INSERT :
                   (roll < 70) ? pls_pkg::FUNC_REMOVE_LAST : pls_pkg::FUNC_REMOVE_AT;
        roll = $urandom_range(0, 9);
        word = (roll == 0) ? '0 : (roll == 1) ? '1 : pls_pkg::WORD_W'($urandom);
        send_req(func, pls_pkg::POS_W'($urandom_range(0, 15)), word);
    endtask

    initial
    begin
        int unsigned i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list and unknown codes
        send_req(pls_pkg::FUNC_READ, 4'd0, 32'h1234_5678);
        send_req(pls_pkg::FUNC_REMOVE_LAST, 4'd0, '0);
        send_req(pls_pkg::FUNC_REMOVE_AT, 4'd0, '0);
        send_req(FUNC_UNUSED_LO, 4'd0, '1);
        send_req(FUNC_UNUSED_LO + 3'd1, 4'd15, '1);
        send_req(FUNC_UNUSED_HI, 4'd15, '1);
        // inserts, including past the end
        send_req(pls_pkg::FUNC_APPEND, 4'd15, '0);
        send_req(pls_pkg::FUNC_APPEND, 4'd0, '1);
        send_req(pls_pkg::FUNC_INSERT, 4'd0, 32'hA5A5_5A5A);
        send_req(pls_pkg::FUNC_INSERT, 4'd15, 32'h5A5A_A5A5);
        send_req(pls_pkg::FUNC_INSERT, 4'd2, 32'h0000_0001);
        send_req(pls_pkg::FUNC_READ, 4'd0, '0);
        send_req(pls_pkg::FUNC_READ, 4'd4, '1);
        send_req(pls_pkg::FUNC_READ, 4'd5, '0);
        send_req(pls_pkg::FUNC_READ, 4'd15, '0);
        // removes in and out of range
        send_req(pls_pkg::FUNC_REMOVE_AT, 4'd15, '0);
        send_req(pls_pkg::FUNC_REMOVE_AT, 4'd1, '1);
        send_req(pls_pkg::FUNC_REMOVE_AT, 4'd0, '0);
        send_req(pls_pkg::FUNC_REMOVE_LAST, 4'd7, '0);
        send_req(pls_pkg::FUNC_READ, 4'd1, '0);
        send_req(pls_pkg::FUNC_READ, 4'd0, '0);

        // alternate fill-heavy and drain-heavy stretches to hit full and empty often
        for (i = 0; i < RAND_REQS; i++)
        begin
            if (i == QUIET_AT)
                quiet = 1'b1;
            if (i == HOLD_AT)
                long_hold_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                while (shadow.pending() != 0)
                    @(negedge clk);
            end
            send_random(((i / 40) % 2) == 0);
        end
        in_valid <= 1'b0;

        while (shadow.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pls_pkg.sv
hw/rtl/pls_datapath.sv
hw/rtl/pls_ctrl.sv
hw/rtl/positional_list_store_top.sv
verif/tb_positional_list_store_top.sv
